// File: hw/rtl/atfc_pkg.sv
// shared types and constants of the averaged temperature focus compensation unit
package atfc_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int OFFSET_W  = 16;
    localparam int COEF_W    = 8;
    localparam int NCFG_W    = 11;
    localparam int CORR_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 16;

    // saturation limits of a q8.8 value and of a correction
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int CORR_MAX   = 32767;
    localparam int CORR_MIN   = -32768;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_COEF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_ENABLE = 2'd3;

    localparam logic [NCFG_W-1:0] INTEG_COUNT_RESET = 11'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } atfc_state_t;

endpackage

// File: hw/rtl/averaged_temp_focus_compensation_unit.sv
// top level of the averaged temperature focus compensation unit
//
// Averages signed q8.8 temperature samples in blocks of integration_count
// (the previous average counts as one sample) and turns the drift of the
// averaged temperature into a signed motor step correction. Every input item
// yields exactly one result item. A sample (cmd 0) or query (cmd 1) that does
// not close an averaging block goes from acceptance through the emit state into
// the result register, and the next item is taken once the fsm is back in idle. A
// sample that closes a block runs the bit-serial divider, one quotient bit per
// cycle over the accumulator width (27 bits at the default MAX_INTEGRATION), and
// passes through the divide and emit states to the result register before the
// next item can be taken. A result stalled on the result channel adds its wait
// only when a second item is ready to leave behind it. One item is worked on at a
// time, but the next item is taken while a finished result still waits on the
// result channel. The user must write configuration through cfg_wr_en, cfg_index
// and cfg_wdata only while no item is in flight; the block does not enforce this.
module averaged_temp_focus_compensation_unit #(
    parameter int MAX_INTEGRATION = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [atfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [atfc_pkg::CFG_DW-1:0]       cfg_wdata,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // [15:0] sample
    input  logic [1:0]                        s_tuser,  // [0] cmd, [1] sample_fault
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // [15:0] correction_steps, [31:16] temperature_out
    output logic [0:0]                        m_tuser   // [0] comp_active
);
    import atfc_pkg::*;

    // block counter holds up to the largest block size
    localparam int CNT_W = $clog2(MAX_INTEGRATION + 1);
    // accumulator: one sample times the largest block, plus sign
    localparam int ACC_W = SAMPLE_W + $clog2(MAX_INTEGRATION) + 1;
    localparam int SUM_W = ACC_W + 1;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + COEF_W;
    localparam int CQ_W = PROD_W - 8;

    // configuration registers
    logic [NCFG_W-1:0]          n_cfg_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic signed [COEF_W-1:0]   coef_reg;
    logic                       enable_reg;

    // averaging state
    atfc_state_t                state_reg, state_next;
    logic                       seeded_reg, seeded_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] cur_reg, cur_next;
    logic signed [SAMPLE_W-1:0] ref_reg, ref_next;
    logic                       ready_reg, ready_next;
    logic signed [CORR_W-1:0]   corr_reg, corr_next;

    // result register
    logic                       m_valid_reg, m_valid_next;
    logic [31:0]                m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;

    // input fields
    logic                       in_cmd;
    logic                       in_fault;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       accept;
    logic                       emit_load;

    // datapath
    logic [31:0]                n_wide;
    logic [CNT_W-1:0]           n_eff;
    logic signed [ACC_W-1:0]    acc_sum;
    logic [CNT_W:0]             cnt_inc;
    logic                       block_full;
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic signed [ACC_W-1:0]    div_q;
    logic signed [SUM_W-1:0]    avg_sum;
    logic signed [SAMPLE_W-1:0] avg_sat;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [CQ_W-1:0]     corr_q;
    logic signed [CORR_W-1:0]   corr_sat;

    assign in_sample = $signed(s_tdata[SAMPLE_W-1:0]);
    assign in_cmd    = s_tuser[0];
    assign in_fault  = s_tuser[1];
    assign accept    = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_cfg_reg  <= INTEG_COUNT_RESET;
            offset_reg <= '0;
            coef_reg   <= '0;
            enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_INTEG_COUNT: n_cfg_reg  <= cfg_wdata[NCFG_W-1:0];
                CFG_TEMP_OFFSET: offset_reg <= $signed(cfg_wdata[OFFSET_W-1:0]);
                CFG_COMP_COEF:   coef_reg   <= $signed(cfg_wdata[COEF_W-1:0]);
                CFG_COMP_ENABLE: enable_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // block size clamped to 2 .. MAX_INTEGRATION
    always_comb begin
        n_wide = 32'(n_cfg_reg);
        if (n_wide < 32'd2) begin
            n_wide = 32'd2;
        end else if (n_wide > 32'(MAX_INTEGRATION)) begin
            n_wide = 32'(MAX_INTEGRATION);
        end
    end
    assign n_eff = n_wide[CNT_W-1:0];

    // next sample into the running block
    assign acc_sum    = acc_reg + ACC_W'(in_sample);
    assign cnt_inc    = {1'b0, cnt_reg} + 1'b1;
    assign block_full = cnt_inc >= {1'b0, n_eff};
    assign div_start  = accept && in_cmd == CMD_SAMPLE && !in_fault && seeded_reg && block_full;

    atfc_serial_div #(
        .ACC_W(ACC_W),
        .DIV_W(CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_sum),
        .divisor  (n_eff),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // new average plus offset, saturated to the sample range
    assign avg_sum = SUM_W'(div_q) + SUM_W'(offset_reg);
    always_comb begin
        if (avg_sum > $signed(SUM_W'(SAMPLE_MAX))) begin
            avg_sat = $signed(SAMPLE_W'(SAMPLE_MAX));
        end else if (avg_sum < $signed(SUM_W'(SAMPLE_MIN))) begin
            avg_sat = $signed(SAMPLE_W'(SAMPLE_MIN));
        end else begin
            avg_sat = avg_sum[SAMPLE_W-1:0];
        end
    end

    // correction: (reference - current) * coefficient / 256, toward zero
    assign diff = DIFF_W'(ref_reg) - DIFF_W'(cur_reg);
    assign prod = PROD_W'(diff) * PROD_W'(coef_reg);
    always_comb begin
        corr_q = prod[PROD_W-1:8];
        if (prod[PROD_W-1] && prod[7:0] != 8'd0) begin
            corr_q = corr_q + 1'b1;
        end
        if (corr_q > $signed(CQ_W'(CORR_MAX))) begin
            corr_sat = $signed(CORR_W'(CORR_MAX));
        end else if (corr_q < $signed(CQ_W'(CORR_MIN))) begin
            corr_sat = $signed(CORR_W'(CORR_MIN));
        end else begin
            corr_sat = corr_q[CORR_W-1:0];
        end
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        emit_load = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EMIT: emit_load = !m_valid_reg || m_tready;
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (div_start) begin
                    state_next = ST_DIV;
                end else if (accept) begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // averaging state and result register
    always_comb begin
        seeded_next  = seeded_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        ref_next     = ref_reg;
        ready_next   = ready_reg;
        corr_next    = corr_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (accept) begin
            corr_next = '0;
            if (in_cmd == CMD_SAMPLE) begin
                if (!in_fault) begin
                    if (!seeded_reg) begin
                        // first good sample seeds everything
                        seeded_next = 1'b1;
                        acc_next    = ACC_W'(in_sample);
                        cur_next    = in_sample;
                        ref_next    = in_sample;
                        cnt_next    = CNT_W'(1);
                    end else if (block_full) begin
                        cnt_next = CNT_W'(1);
                    end else begin
                        acc_next = acc_sum;
                        cnt_next = cnt_inc[CNT_W-1:0];
                    end
                end
            end else if (ready_reg && enable_reg) begin
                corr_next = corr_sat;
                if (corr_sat != '0) begin
                    ref_next = cur_reg;
                end
            end
        end

        // block closed: quotient becomes the running average
        if (state_reg == ST_DIV && div_done) begin
            acc_next   = div_q;
            cur_next   = avg_sat;
            ready_next = 1'b1;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (emit_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {cur_reg, corr_reg};
            m_user_next  = ready_reg && enable_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seeded_reg  <= 1'b0;
            acc_reg     <= '0;
            cnt_reg     <= CNT_W'(1);
            cur_reg     <= '0;
            ref_reg     <= '0;
            ready_reg   <= 1'b0;
            corr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seeded_reg  <= seeded_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            cur_reg     <= cur_next;
            ref_reg     <= ref_next;
            ready_reg   <= ready_next;
            corr_reg    <= corr_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // the divider only runs while the fsm waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider busy outside the divide state");

    // a closed block always marks the average ready before the result goes out
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && div_done |=> state_reg == ST_EMIT && ready_reg)
        else $error("block close did not reach the result stage");

    // no average can exist before the first sample seeded the state
    assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> seeded_reg)
        else $error("average ready without seeding");

    // the running block always holds at least the previous average
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0)
        else $error("block counter dropped to zero");

endmodule

// File: hw/rtl/atfc_serial_div.sv
// bit-serial restoring divider: signed dividend by unsigned divisor, truncating toward zero
module atfc_serial_div #(
    parameter int ACC_W = 27,
    parameter int DIV_W = 11
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic        [DIV_W-1:0] divisor,
    output logic                    busy,
    output logic                    done,
    output logic signed [ACC_W-1:0] quotient
);
    import atfc_pkg::*;

    localparam int STEP_W = $clog2(ACC_W);

    logic [ACC_W-1:0]  shift_reg, shift_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_W:0]    rem_sh;
    logic [DIV_W:0]    trial;

    // one quotient bit per cycle, msb first
    assign rem_sh = {rem_reg, shift_reg[ACC_W-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            neg_next   = dividend[ACC_W-1];
            shift_next = dividend[ACC_W-1] ? (ACC_W'(0) - dividend) : dividend;
            rem_next   = '0;
            dvs_next   = divisor;
            step_next  = STEP_W'(ACC_W - 1);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_W]) begin
                rem_next   = trial[DIV_W-1:0];
                shift_next = {shift_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_next   = rem_sh[DIV_W-1:0];
                shift_next = {shift_reg[ACC_W-2:0], 1'b0};
            end
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        step_reg  <= step_next;
        neg_reg   <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(ACC_W'(0) - shift_reg) : $signed(shift_reg);

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && step_reg == '0 |=> done_reg)
        else $error("divider missed its done pulse");

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");

endmodule

// File: dv/averaged_temp_focus_compensation_unit_test.sv
// self-checking stream testbench for the averaged temperature focus compensation unit
`timescale 1ns / 100ps

module averaged_temp_focus_compensation_unit_test;
    import atfc_pkg::*;

    // same limit as the default build of the block
    localparam int MAX_AVG      = 1024;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 116;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_LIMIT = 50;

    // one input item and one result item as the block sees them
    typedef struct packed {
        logic               cmd;
        logic signed [15:0] sample;
        logic               fault;
    } focus_item_t;

    typedef struct packed {
        logic signed [15:0] correction;
        logic               active;
        logic signed [15:0] temperature;
    } focus_result_t;

    // directed stimulus: either an item or a register write
    typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        focus_item_t          item;
        bit                   known;     // expected result typed in below
        focus_result_t        want;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DW-1:0]    reg_val;
    } table_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;   // [15:0] sample
    logic [1:0]           s_tuser   = '0;   // [0] cmd, [1] sample_fault
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;          // [15:0] correction_steps, [31:16] temperature_out
    logic [0:0]           m_tuser;          // [0] comp_active

    // predictor copy of the block's state and registers
    bit          avg_seeded;
    longint      acc_sum;
    int          block_fill;
    int          cur_temp;
    int          ref_temp;
    bit          avg_ready;
    logic [10:0] n_cfg;
    int          offset_cfg;
    int          coef_cfg;
    bit          enable_cfg;

    focus_result_t due_results[$];   // results still owed by the block, oldest first
    focus_result_t due;
    table_row_t    stimulus_table[$];

    int drift_level;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_served = 0;
    int hold_left    = 0;
    int items_sent;
    int results_seen = 0;
    int mismatches   = 0;

    averaged_temp_focus_compensation_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    // generous ceiling on the whole run, several times the slowest correct one
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clamp16(input longint v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < SAMPLE_MIN) return SAMPLE_MIN;
        return int'(v);
    endfunction

    // works out the result of one accepted item and advances the predictor state
    function automatic focus_result_t compensate(input focus_item_t it);
        focus_result_t res;
        int            n;
        longint        diff;
        longint        corr;
        corr = 0;
        // counts below 2 act as 2, counts above the limit act as the limit
        n = (n_cfg < 2) ? 2 : ((n_cfg > MAX_AVG) ? MAX_AVG : int'(n_cfg));
        if (it.cmd == CMD_SAMPLE) begin
            if (!it.fault) begin
                if (!avg_seeded) begin
                    // first good sample seeds average, temperature and reference
                    avg_seeded = 1'b1;
                    acc_sum    = longint'(it.sample);
                    cur_temp   = int'(it.sample);
                    ref_temp   = int'(it.sample);
                    block_fill = 1;
                end else begin
                    acc_sum    += longint'(it.sample);
                    block_fill += 1;
                    // a lowered count closes the block on the next good sample
                    if (block_fill >= n) begin
                        acc_sum    = acc_sum / n;
                        block_fill = 1;
                        cur_temp   = clamp16(acc_sum + offset_cfg);
                        avg_ready  = 1'b1;
                    end
                end
            end
        end else if (avg_ready && enable_cfg) begin
            diff = longint'(ref_temp) - longint'(cur_temp);
            corr = clamp16((diff * coef_cfg) / 256);
            if (corr != 0) ref_temp = cur_temp;
        end
        res.correction  = corr[15:0];
        res.active      = avg_ready && enable_cfg;
        res.temperature = cur_temp[15:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        // keep the log short when everything goes wrong
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ns, result %0d: %s is %0d, expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    function automatic void put_item(input logic cmd, input logic [15:0] smp, input logic flt,
                                     input bit known, input int corr, input bit act,
                                     input int temp);
        table_row_t row;
        row.kind                 = ROW_ITEM;
        row.item.cmd             = cmd;
        row.item.sample          = smp;
        row.item.fault           = flt;
        row.known                = known;
        row.want.correction      = corr[15:0];
        row.want.active          = act;
        row.want.temperature     = temp[15:0];
        row.reg_idx              = '0;
        row.reg_val              = '0;
        stimulus_table.push_back(row);
    endfunction

    function automatic void put_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DW-1:0] val);
        table_row_t row;
        row.kind    = ROW_WRITE;
        row.item    = '0;
        row.known   = 1'b0;
        row.want    = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        stimulus_table.push_back(row);
    endfunction

    // register write; the predictor copy is updated at the falling edge after the register takes the write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INTEG_COUNT: n_cfg      = val[10:0];
            CFG_TEMP_OFFSET: offset_cfg = int'($signed(val));
            CFG_COMP_COEF:   coef_cfg   = int'($signed(val[7:0]));
            CFG_COMP_ENABLE: enable_cfg = val[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // stop offering items and wait until every owed result has been taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // offers one item, called and returning at a falling edge
    task automatic send_item(input focus_item_t it, input bit known, input focus_result_t want);
        focus_result_t predicted;
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.sample;
        s_tuser  <= {it.fault, it.cmd};
        do @(posedge aclk); while (!s_tready);
        predicted = compensate(it);
        due_results.push_back(known ? want : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    // mostly samples drifting slowly around a level, with queries mixed in
    // and a share of faulty or wild readings
    function automatic focus_item_t random_item();
        focus_item_t it;
        it.cmd   = (int'($urandom_range(99)) < 30) ? CMD_QUERY : CMD_SAMPLE;
        it.fault = int'($urandom_range(99)) < 8;
        if (int'($urandom_range(99)) < 20) begin
            it.sample = 16'($urandom);
        end else begin
            drift_level = clamp16(drift_level + int'($urandom_range(400)) - 200);
            it.sample   = 16'(clamp16(drift_level + int'($urandom_range(63)) - 32));
        end
        return it;
    endfunction

    // result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            m_tready     <= 1'b0;
            hold_left    <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end else begin
            m_tready <= int'($urandom_range(99)) >= recv_stall_pct;
        end
    end

    // compare each delivered result with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, correction_steps",
                                int'($signed(m_tdata[15:0])), 0);
            end else begin
                due = due_results.pop_front();
                if (m_tdata[15:0] !== due.correction)
                    report_mismatch("correction_steps", int'($signed(m_tdata[15:0])),
                                    int'(due.correction));
                if (m_tuser[0] !== due.active)
                    report_mismatch("comp_active", int'(m_tuser[0]), int'(due.active));
                if (m_tdata[31:16] !== due.temperature)
                    report_mismatch("temperature_out", int'($signed(m_tdata[31:16])),
                                    int'(due.temperature));
            end
        end
    end

    initial begin : stimulus
        int            phase;
        int            k;
        int            directed_items;
        logic [15:0]   cnt_val;
        logic [15:0]   off_val;
        logic [15:0]   coef_val;
        focus_result_t none;

        none           = '0;
        avg_seeded     = 1'b0;
        acc_sum        = 0;
        block_fill     = 1;
        cur_temp       = 0;
        ref_temp       = 0;
        avg_ready      = 1'b0;
        n_cfg          = INTEG_COUNT_RESET;
        offset_cfg     = 0;
        coef_cfg       = 0;
        enable_cfg     = 1'b0;
        drift_level    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        items_sent     = 0;

        // query and faulty sample straight after reset, then seed at the minimum
        put_item(CMD_QUERY,  16'h0000, 1'b0, 1, 0, 0, 0);
        put_item(CMD_SAMPLE, 16'h1234, 1'b1, 1, 0, 0, 0);
        put_item(CMD_SAMPLE, 16'h8000, 1'b0, 1, 0, 0, -32768);
        // shortest block: min and max average to zero
        put_write(CFG_INTEG_COUNT, 16'd2);
        put_item(CMD_SAMPLE, 16'h7FFF, 1'b0, 1, 0, 0, 0);
        // largest positive coefficient, then a query with nothing left to correct
        put_write(CFG_COMP_ENABLE, 16'd1);
        put_write(CFG_COMP_COEF, 16'h007F);
        put_item(CMD_QUERY,  16'h0000, 1'b0, 1, -16256, 1, 0);
        put_item(CMD_QUERY,  16'h0000, 1'b0, 1, 0, 1, 0);
        // offset pushes the average past the top of the range
        put_write(CFG_TEMP_OFFSET, 16'h7FFF);
        put_item(CMD_SAMPLE, 16'h7FFF, 1'b0, 1, 0, 1, 32767);
        put_write(CFG_COMP_COEF, 16'h0080);
        put_item(CMD_QUERY,  16'h0000, 1'b0, 1, 16383, 1, 32767);
        // negative average truncates toward zero, offset saturates at the bottom
        put_write(CFG_TEMP_OFFSET, 16'h8000);
        put_item(CMD_SAMPLE, 16'h8000, 1'b0, 1, 0, 1, -32768);
        // full-scale drift, sample field on a query is ignored
        put_item(CMD_QUERY,  16'hFFFF, 1'b0, 1, -32767, 1, -32768);
        // disabled: no correction and no active flag; fault bit on a query
        put_write(CFG_COMP_ENABLE, 16'd0);
        put_item(CMD_QUERY,  16'hFFFF, 1'b1, 1, 0, 0, -32768);
        put_item(CMD_SAMPLE, 16'h7FFF, 1'b1, 1, 0, 0, -32768);
        // count of zero acts as two
        put_write(CFG_TEMP_OFFSET, 16'h0000);
        put_write(CFG_INTEG_COUNT, 16'd0);
        put_write(CFG_COMP_ENABLE, 16'd1);
        put_item(CMD_SAMPLE, 16'h0100, 1'b0, 0, 0, 0, 0);
        put_item(CMD_QUERY,  16'h0000, 1'b0, 0, 0, 0, 0);
        // all count bits set acts as the limit, then the count drops mid-block
        put_write(CFG_INTEG_COUNT, 16'hFFFF);
        put_item(CMD_SAMPLE, 16'h0A00, 1'b0, 0, 0, 0, 0);
        put_item(CMD_SAMPLE, 16'h0B80, 1'b0, 0, 0, 0, 0);
        put_item(CMD_SAMPLE, 16'hF600, 1'b0, 0, 0, 0, 0);
        put_item(CMD_SAMPLE, 16'h0C40, 1'b0, 0, 0, 0, 0);
        put_write(CFG_INTEG_COUNT, 16'd3);
        put_item(CMD_SAMPLE, 16'h0D00, 1'b0, 0, 0, 0, 0);
        put_item(CMD_QUERY,  16'h0000, 1'b0, 0, 0, 0, 0);
        // count of one acts as two
        put_write(CFG_INTEG_COUNT, 16'd1);
        put_item(CMD_SAMPLE, 16'h2AAA, 1'b0, 0, 0, 0, 0);
        put_item(CMD_QUERY,  16'h5555, 1'b0, 0, 0, 0, 0);

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stimulus_table[i]) begin
            if (stimulus_table[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(stimulus_table[i].reg_idx, stimulus_table[i].reg_val);
            end else begin
                send_item(stimulus_table[i].item, stimulus_table[i].known,
                          stimulus_table[i].want);
            end
        end
        directed_items = items_sent;

        // random phases, two per idling pattern: none, sender, receiver, both
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            // new settings for the phase, extremes on some of them
            cnt_val  = (phase == 0) ? 16'd2 : (phase == 5) ? 16'd24 : 16'($urandom_range(6));
            off_val  = (phase == 3) ? 16'h7FFF : (phase == 4) ? 16'h8000
                     : 16'(int'($urandom_range(1023)) - 512);
            coef_val = (phase == 6) ? 16'h0080 : (phase == 0 || phase == 7) ? 16'h007F
                     : 16'($urandom_range(255));
            write_reg(CFG_INTEG_COUNT, cnt_val);
            write_reg(CFG_TEMP_OFFSET, off_val);
            write_reg(CFG_COMP_COEF, coef_val);
            write_reg(CFG_COMP_ENABLE, (phase == 4) ? 16'd0 : 16'd1);
            // result side stops for a long while as the sender keeps pushing
            if (phase == 1) hold_requests++;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // sender waits for the block to drain completely once
                if (phase == 2 && k == PHASE_ITEMS / 2) wait_idle();
                send_item(random_item(), 1'b0, none);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("run: %0d items (%0d directed), %0d results checked, %0d mismatches",
                 items_sent, directed_items, results_seen, mismatches);
        $display("covered: register extremes, %0d random phases with idling and a long stall",
                 PHASES);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/atfc_pkg.sv
hw/rtl/atfc_serial_div.sv
hw/rtl/averaged_temp_focus_compensation_unit.sv
dv/averaged_temp_focus_compensation_unit_test.sv
